### rtl/mst_pkg.sv
// Shared types and constants for the multi-slot soft timer.
// Used by the controller, the datapath, the top level and the checker.
package mst_pkg;

  // command item
  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  slot;
    logic [31:0] interval;
    logic        periodic;
  } cmd_item_t;

  // result item
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic [31:0] count_value;
    logic        last;
  } rsp_item_t;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_POLL    = 3'd1;
  localparam logic [2:0] OP_ADD     = 3'd2;
  localparam logic [2:0] OP_DELETE  = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;
  localparam logic [2:0] OP_QUERY   = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFREE   = 3'd1;
  localparam logic [2:0] ST_BADIDX   = 3'd2;
  localparam logic [2:0] ST_INACTIVE = 3'd3;
  localparam logic [2:0] ST_FIRED    = 3'd4;

  // source of the slot_index field of an emitted result
  localparam logic [1:0] IDX_ZERO = 2'd0;
  localparam logic [1:0] IDX_SCAN = 2'd1;
  localparam logic [1:0] IDX_CMD  = 2'd2;

  localparam logic [15:0] TICK_STEP_RESET = 16'd10;
  localparam logic [3:0]  MAX_FIRES       = 4'd8;
  localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       scan_clr;
    logic       scan_inc;
    logic       addr_scan;
    logic       do_tick;
    logic       do_count;
    logic       do_fire;
    logic       do_add;
    logic       do_delete;
    logic       do_restart;
    logic       emit;
    logic [2:0] emit_status;
    logic [1:0] emit_idx_sel;
    logic       emit_cnt;
    logic       emit_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       scan_last;
    logic       due;
    logic       rd_active;
    logic       bad_index;
    logic       total_zero;
    logic       total_full;
    logic       fire_last;
    logic       out_free;
  } dp_stat_t;

endpackage

### rtl/mst_ctrl.sv
// Command sequencer for the multi-slot soft timer.
// Depends on mst_pkg; drives mst_datapath through dp_cmd_t.
module mst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  mst_pkg::dp_stat_t stat,
  output mst_pkg::dp_cmd_t  ctl,
  output logic              busy
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_TICK     = 3'd2;
  localparam logic [2:0] S_COUNT    = 3'd3;
  localparam logic [2:0] S_FIRE     = 3'd4;
  localparam logic [2:0] S_FIND     = 3'd5;
  localparam logic [2:0] S_SINGLE   = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.load     = 1'b1;
          ctl.scan_clr = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op) inside
          mst_pkg::OP_TICK:  state_next = S_TICK;
          mst_pkg::OP_POLL:  state_next = S_COUNT;
          mst_pkg::OP_ADD:   state_next = S_FIND;
          mst_pkg::OP_DELETE, mst_pkg::OP_RESTART, mst_pkg::OP_QUERY:
            state_next = S_SINGLE;
          default:           state_next = S_IDLE;
        endcase
      end
      S_TICK: begin
        ctl.addr_scan = 1'b1;
        ctl.do_tick   = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DONE;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_COUNT: begin
        // first pass: count due slots, capped, no state change
        ctl.addr_scan = 1'b1;
        ctl.do_count  = stat.due && !stat.total_full;
        if (stat.scan_last) begin
          ctl.scan_clr = 1'b1;
          state_next   = S_FIRE;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_FIRE: begin
        // second pass: the same slots are due again, emit them in order
        ctl.addr_scan = 1'b1;
        if (stat.total_zero) begin
          state_next = S_DONE;
        end else if (stat.due) begin
          if (stat.out_free) begin
            ctl.do_fire      = 1'b1;
            ctl.emit         = 1'b1;
            ctl.emit_status  = mst_pkg::ST_FIRED;
            ctl.emit_idx_sel = mst_pkg::IDX_SCAN;
            ctl.emit_last    = stat.fire_last;
            if (stat.fire_last) begin
              state_next = S_IDLE;
            end else begin
              ctl.scan_inc = 1'b1;
            end
          end
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_FIND: begin
        ctl.addr_scan = 1'b1;
        if (!stat.rd_active) begin
          if (stat.out_free) begin
            ctl.do_add       = 1'b1;
            ctl.emit         = 1'b1;
            ctl.emit_status  = mst_pkg::ST_OK;
            ctl.emit_idx_sel = mst_pkg::IDX_SCAN;
            ctl.emit_last    = 1'b1;
            state_next       = S_IDLE;
          end
        end else if (stat.scan_last) begin
          if (stat.out_free) begin
            ctl.emit         = 1'b1;
            ctl.emit_status  = mst_pkg::ST_NOFREE;
            ctl.emit_idx_sel = mst_pkg::IDX_ZERO;
            ctl.emit_last    = 1'b1;
            state_next       = S_IDLE;
          end
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_SINGLE: begin
        if (stat.out_free) begin
          ctl.emit         = 1'b1;
          ctl.emit_idx_sel = mst_pkg::IDX_CMD;
          ctl.emit_last    = 1'b1;
          state_next       = S_IDLE;
          if (stat.bad_index) begin
            ctl.emit_status = mst_pkg::ST_BADIDX;
          end else if (stat.op == mst_pkg::OP_DELETE) begin
            ctl.do_delete   = 1'b1;
            ctl.emit_status = mst_pkg::ST_OK;
          end else if (!stat.rd_active) begin
            ctl.emit_status = mst_pkg::ST_INACTIVE;
          end else if (stat.op == mst_pkg::OP_RESTART) begin
            ctl.do_restart  = 1'b1;
            ctl.emit_status = mst_pkg::ST_OK;
          end else begin
            ctl.emit_status = mst_pkg::ST_OK;
            ctl.emit_cnt    = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.emit         = 1'b1;
          ctl.emit_status  = mst_pkg::ST_OK;
          ctl.emit_idx_sel = mst_pkg::IDX_ZERO;
          ctl.emit_last    = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/mst_datapath.sv
// Slot table, tick step register, scan counters and result register.
// Depends on mst_pkg; commanded by mst_ctrl.
module mst_datapath #(
  parameter int SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  mst_pkg::cmd_item_t cmd_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  mst_pkg::dp_cmd_t   ctl,
  output mst_pkg::dp_stat_t  stat,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output mst_pkg::rsp_item_t rsp_item
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  mst_pkg::cmd_item_t cmd;
  logic [15:0]        tick_step;
  logic [SW-1:0]      idx;
  logic [3:0]         total;
  logic [3:0]         emitted;

  logic [31:0]        count_mem [SLOTS];
  logic [31:0]        intv_mem  [SLOTS];
  logic [SLOTS-1:0]   active;
  logic [SLOTS-1:0]   periodic;

  logic [SW-1:0]      addr;
  logic [31:0]        rd_count;
  logic [31:0]        rd_intv;
  logic               rd_active;
  logic               rd_periodic;
  logic [32:0]        tick_sum;
  logic [31:0]        tick_val;
  logic               out_free;
  logic [3:0]         emit_idx;

  assign addr        = ctl.addr_scan ? idx : cmd.slot[SW-1:0];
  assign rd_count    = count_mem[addr];
  assign rd_intv     = intv_mem[addr];
  assign rd_active   = active[addr];
  assign rd_periodic = periodic[addr];

  // saturating add of the tick step
  assign tick_sum = {1'b0, rd_count} + {17'b0, tick_step};
  assign tick_val = tick_sum[32] ? mst_pkg::COUNT_MAX : tick_sum[31:0];

  assign out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    stat            = '0;
    stat.op         = cmd.operation;
    stat.scan_last  = (idx == SW'(SLOTS - 1));
    stat.due        = rd_active && (rd_count >= rd_intv);
    stat.rd_active  = rd_active;
    stat.bad_index  = (cmd.slot >= 4'(SLOTS));
    stat.total_zero = (total == 4'd0);
    stat.total_full = (total == mst_pkg::MAX_FIRES);
    stat.fire_last  = ((emitted + 4'd1) == total);
    stat.out_free   = out_free;
  end

  always_comb begin
    case (ctl.emit_idx_sel)
      mst_pkg::IDX_SCAN: emit_idx = 4'(idx);
      mst_pkg::IDX_CMD:  emit_idx = cmd.slot;
      default:           emit_idx = 4'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= mst_pkg::TICK_STEP_RESET;
    end else if (cfg_we) begin
      tick_step <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= cmd_item;
    end
    if (ctl.scan_clr) begin
      idx <= '0;
    end else if (ctl.scan_inc) begin
      idx <= idx + SW'(1);
    end
    if (ctl.load) begin
      total   <= '0;
      emitted <= '0;
    end else begin
      if (ctl.do_count) begin
        total <= total + 4'd1;
      end
      if (ctl.do_fire) begin
        emitted <= emitted + 4'd1;
      end
    end
  end

  // slot table: count, interval and periodic mark need no reset
  always_ff @(posedge clk) begin
    if (ctl.do_tick && rd_active) begin
      count_mem[addr] <= tick_val;
    end else if (ctl.do_fire || ctl.do_add || ctl.do_restart) begin
      count_mem[addr] <= '0;
    end
    if (ctl.do_add) begin
      intv_mem[addr] <= cmd.interval;
      periodic[addr] <= cmd.periodic;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (ctl.do_add) begin
      active[addr] <= 1'b1;
    end else if (ctl.do_delete || (ctl.do_fire && !rd_periodic)) begin
      active[addr] <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      rsp_item.status      <= ctl.emit_status;
      rsp_item.slot_index  <= emit_idx;
      rsp_item.count_value <= ctl.emit_cnt ? rd_count : 32'd0;
      rsp_item.last        <= ctl.emit_last;
    end
  end

endmodule

### rtl/multi_slot_soft_timer.sv
// Multi-slot soft timer: tick, poll, add, delete, restart and query commands.
// Delete, restart and query give a single result; tick scans every slot, then reports once;
// add scans for the first free slot; poll counts due slots in one pass, then fires them in a second.
// One command at a time: next accept the cycle after its last result is loaded; the slot
// scan goes through one table port and one adder.
// Synchronous rst clears active marks, sequencer and result valid, and sets tick_step to 10.
module multi_slot_soft_timer #(
  parameter int SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  mst_pkg::cmd_item_t cmd_item,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output mst_pkg::rsp_item_t rsp_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  mst_pkg::dp_cmd_t  ctl;
  mst_pkg::dp_stat_t stat;
  logic              busy;

  assign cmd_stall = rst || busy;
  assign cfg_ready = !rst;

  mst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .stat      (stat),
    .ctl       (ctl),
    .busy      (busy)
  );

  mst_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd_item  (cmd_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

endmodule

### rtl/mst_checker.sv
// Port-level checks for the multi-slot soft timer, bound to the top level.
// Depends on mst_pkg.
module mst_props (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input mst_pkg::rsp_item_t rsp_item
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
    else $error("stalled result changed");

  // one command at a time: busy right after an accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command accepted while previous one in progress");

  // only poll produces more than one item per command
  a_non_last_is_fire: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_item.last |-> rsp_item.status == mst_pkg::ST_FIRED)
    else $error("non-final item that is not a fired report");

  // count is only carried on a successful query
  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.status != mst_pkg::ST_OK |-> rsp_item.count_value == 32'd0)
    else $error("count_value set on a non-ok item");

endmodule

bind multi_slot_soft_timer mst_props u_chk (.*);
